FILE: src/tsplit_pkg.sv
package tsplit_pkg;

  // Largest payload a length header may announce, in bytes
  localparam int unsigned MAX_PAYLOAD = 32'd16777216;
  localparam int unsigned REM_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned PAY_W       = 34;  // 32-bit word count times four

  localparam logic [PAY_W-1:0] PAY_MAX = PAY_W'(MAX_PAYLOAD);

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [1:0] MODE_ABRIDGED     = 2'd0;
  localparam logic [1:0] MODE_INTERMEDIATE = 2'd1;
  localparam logic [1:0] MODE_PADDED       = 2'd2;
  localparam logic [1:0] MODE_UNKNOWN      = 2'd3;

  // Abridged first bytes that announce a three-byte word count
  localparam logic [7:0] ABR_LONG_A = 8'h7F;
  localparam logic [7:0] ABR_LONG_B = 8'hFF;

endpackage

FILE: src/transport_packet_splitter_top.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    opcode, cipher_byte, plain_byte, chunk_last
// out      out_valid / out_ready  has_byte, out_byte, ends_group, passthrough
// cfg      cfg_wr_en              cfg_wr_data (protocol_mode)
//
// One transaction per cycle sustained while out_ready stays high; the result
// passes through the input register, then the result register.
// Header and counter state update as an item moves from the input register
// into the result register, so each item sees the state left by the last.
// A stalled result register holds the input register, which then drops in_ready.
// rst is synchronous and clears the framing state, mode and both valid flags.
module transport_packet_splitter_top
  import tsplit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode,
  input  logic [7:0] cipher_byte,
  input  logic [7:0] plain_byte,
  input  logic       chunk_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       has_byte,
  output logic [7:0] out_byte,
  output logic       ends_group,
  output logic       passthrough
);

  // input register
  logic       s1_valid;
  logic       s1_opcode;
  logic [7:0] s1_cipher;
  logic [7:0] s1_plain;
  logic       s1_last;

  // framing state
  logic [1:0]       protocol_mode;
  logic [1:0]       header_index;
  logic [31:0]      length_accum;
  logic [REM_W-1:0] bytes_remaining;
  logic             in_payload;
  logic             stopped;
  logic             group_open;

  logic [1:0]       header_index_next;
  logic [31:0]      length_accum_next;
  logic [REM_W-1:0] bytes_remaining_next;
  logic             in_payload_next;
  logic             stopped_next;
  logic             group_open_next;
  logic             ends_next;

  logic             advance;
  logic [REM_W-1:0] rem_dec;
  logic [1:0]       shift_idx;
  logic [31:0]      accum_or;
  logic [PAY_W-1:0] payload;
  logic             len_done;
  logic             is_abr;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  assign rem_dec   = bytes_remaining - REM_W'(1);
  assign is_abr    = (protocol_mode == MODE_ABRIDGED);
  // abridged counts header bytes after the first, intermediate from the first
  assign shift_idx = is_abr ? (header_index - 2'd1) : header_index;
  assign accum_or  = length_accum | ({24'd0, s1_plain} << {shift_idx, 3'b000});

  always_comb begin
    header_index_next    = header_index;
    length_accum_next    = length_accum;
    bytes_remaining_next = bytes_remaining;
    in_payload_next      = in_payload;
    stopped_next         = stopped;
    group_open_next      = group_open;
    ends_next            = 1'b0;
    payload              = '0;
    len_done             = 1'b0;

    if (s1_opcode == OP_FLUSH) begin
      ends_next            = group_open;
      group_open_next      = 1'b0;
      in_payload_next      = 1'b0;
      bytes_remaining_next = '0;
      header_index_next    = '0;
      length_accum_next    = '0;
    end else if (stopped) begin
      group_open_next = !s1_last;
      ends_next       = s1_last;
    end else if (in_payload) begin
      bytes_remaining_next = rem_dec;
      if (rem_dec == '0) begin
        in_payload_next = 1'b0;
        group_open_next = 1'b0;
        ends_next       = 1'b1;
      end else begin
        group_open_next = 1'b1;
      end
    end else begin
      group_open_next = 1'b1;
      case (protocol_mode)
        MODE_UNKNOWN: begin
          stopped_next         = 1'b1;
          bytes_remaining_next = '0;
          header_index_next    = '0;
          length_accum_next    = '0;
          group_open_next      = !s1_last;
          ends_next            = s1_last;
        end
        MODE_ABRIDGED: begin
          if (header_index == 2'd0) begin
            if (s1_plain == ABR_LONG_A || s1_plain == ABR_LONG_B) begin
              header_index_next = 2'd1;
              length_accum_next = '0;
            end else begin
              len_done = 1'b1;
              payload  = {25'd0, s1_plain[6:0], 2'b00};
            end
          end else begin
            length_accum_next = accum_or;
            header_index_next = header_index + 2'd1;
            if (header_index == 2'd3) begin
              len_done = 1'b1;
              payload  = {accum_or, 2'b00};
            end
          end
        end
        default: begin
          length_accum_next = accum_or;
          header_index_next = header_index + 2'd1;
          if (header_index == 2'd3) begin
            len_done = 1'b1;
            payload  = {3'd0, accum_or[30:0]};
          end
        end
      endcase

      if (len_done) begin
        header_index_next = '0;
        length_accum_next = '0;
        if (payload == '0 || payload > PAY_MAX) begin
          stopped_next         = 1'b1;
          in_payload_next      = 1'b0;
          bytes_remaining_next = '0;
          group_open_next      = !s1_last;
          ends_next            = s1_last;
        end else begin
          bytes_remaining_next = payload[REM_W-1:0];
          in_payload_next      = 1'b1;
          group_open_next      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode   <= MODE_ABRIDGED;
      header_index    <= '0;
      length_accum    <= '0;
      bytes_remaining <= '0;
      in_payload      <= 1'b0;
      stopped         <= 1'b0;
      group_open      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        protocol_mode <= cfg_wr_data;
      end
      if (advance) begin
        header_index    <= header_index_next;
        length_accum    <= length_accum_next;
        bytes_remaining <= bytes_remaining_next;
        in_payload      <= in_payload_next;
        stopped         <= stopped_next;
        group_open      <= group_open_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode <= opcode;
      s1_cipher <= cipher_byte;
      s1_plain  <= plain_byte;
      s1_last   <= chunk_last;
    end
    if (advance) begin
      has_byte    <= (s1_opcode == OP_DATA);
      out_byte    <= (s1_opcode == OP_DATA) ? s1_cipher : 8'd0;
      ends_group  <= ends_next;
      passthrough <= stopped_next;
    end
  end

  // passthrough is permanent until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(stopped))
    else $error("stopped cleared without reset");

  a_payload_not_stopped: assert property (@(posedge clk) disable iff (rst)
    !(in_payload && stopped))
    else $error("payload counting while in passthrough");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (bytes_remaining != '0 && header_index == 2'd0))
    else $error("payload state inconsistent");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_opcode == OP_FLUSH) |=> (!in_payload && !group_open))
    else $error("flush left framing state open");

endmodule
